// ===== rtl/unique_window_pattern_search_core_defines.svh =====
// Assertion macros used by the search core back end.
`ifndef UNIQUE_WINDOW_PATTERN_SEARCH_CORE_DEFINES_SVH
`define UNIQUE_WINDOW_PATTERN_SEARCH_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UWPS_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define UWPS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uwps_pkg.sv =====
package uwps_pkg;

    localparam int NEEDLE_MAX_DEFAULT     = 8192;
    localparam int POSITION_WIDTH_DEFAULT = 24;
    localparam int SAMPLE_WIDTH_DEFAULT   = 32;

    localparam int NLEN_REG_W  = 14;
    localparam int CFG_INDEX_W = 2;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam int RESET_NEEDLE_LENGTH   = 8192;
    localparam int RESET_HAYSTACK_LENGTH = 1024 * 1024;
    localparam int RESET_SEARCH_CAP      = 1024 * 1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_LENGTH   = 2'd0,
        CFG_HAYSTACK_LENGTH = 2'd1,
        CFG_SEARCH_CAP      = 2'd2
    } cfg_index_e;

    typedef enum logic {
        ITEM_NEEDLE   = 1'b0,
        ITEM_HAYSTACK = 1'b1
    } item_kind_e;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_UNIQUE  = 2'd0,
        STATUS_NONE    = 2'd1,
        STATUS_SEVERAL = 2'd2
    } status_e;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_CMP,
        ST_DRAIN,
        ST_TALLY
    } back_state_e;

    // Head of the item queue as seen by the back end.
    typedef struct packed {
        logic       valid;
        item_kind_e kind;
    } q_ctrl_t;

endpackage

// ===== rtl/uwps_front.sv =====
module uwps_front import uwps_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEFAULT
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic                    s_mode,
    input  logic [SAMPLE_WIDTH-1:0] s_sample,
    output q_ctrl_t                 q_ctrl,
    output logic [SAMPLE_WIDTH-1:0] q_sample,
    input  logic                    q_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = PTR_W + 1;
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    item_kind_e              kind_mem   [QUEUE_DEPTH];
    logic [SAMPLE_WIDTH-1:0] sample_mem [QUEUE_DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;

    assign s_ready = (count_reg != FULL_CNT);
    assign push    = s_valid && s_ready;

    assign q_ctrl.valid = (count_reg != '0);
    assign q_ctrl.kind  = kind_mem[rd_ptr_reg];
    assign q_sample     = sample_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !q_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && q_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // The mode bit is classified into an item kind as the beat is queued.
    always_ff @(posedge aclk) begin
        if (push) begin
            kind_mem[wr_ptr_reg]   <= item_kind_e'(s_mode);
            sample_mem[wr_ptr_reg] <= s_sample;
        end
    end

endmodule

// ===== rtl/uwps_back.sv =====
`include "unique_window_pattern_search_core_defines.svh"

module uwps_back import uwps_pkg::*; #(
    parameter int NEEDLE_MAX     = NEEDLE_MAX_DEFAULT,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  q_ctrl_t                   q_ctrl,
    input  logic [SAMPLE_WIDTH-1:0]   q_sample,
    output logic                      q_pop,
    input  logic [NLEN_REG_W-1:0]     needle_length,
    input  logic [POSITION_WIDTH-1:0] haystack_length,
    input  logic [POSITION_WIDTH-1:0] search_cap,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [STATUS_W-1:0]       m_status,
    output logic [POSITION_WIDTH-1:0] m_match_start
);

    localparam int IDX_W  = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
    localparam int CNT_W  = IDX_W + 1;
    localparam int CMP_W  = ((POSITION_WIDTH > CNT_W) ? POSITION_WIDTH : CNT_W) + 1;
    localparam int EXP_W  = (SAMPLE_WIDTH == 64) ? 11 : 8;
    localparam int MANT_W = SAMPLE_WIDTH - 1 - EXP_W;
    localparam logic [SAMPLE_WIDTH-2:0] INF_MAG    = {{EXP_W{1'b1}}, {MANT_W{1'b0}}};
    localparam logic [CNT_W-1:0]        RING_DEPTH = CNT_W'(NEEDLE_MAX);
    localparam logic [IDX_W-1:0]        LAST_SLOT  = IDX_W'(NEEDLE_MAX - 1);

    // IEEE equality: signed zeros are equal and a NaN equals nothing.
    function automatic logic samples_equal(input logic [SAMPLE_WIDTH-1:0] a,
                                           input logic [SAMPLE_WIDTH-1:0] b);
        logic [SAMPLE_WIDTH-2:0] ma;
        logic [SAMPLE_WIDTH-2:0] mb;
        logic                    eq;
        ma = a[SAMPLE_WIDTH-2:0];
        mb = b[SAMPLE_WIDTH-2:0];
        if (ma > INF_MAG || mb > INF_MAG) begin
            eq = 1'b0;
        end else if (ma == '0 && mb == '0) begin
            eq = 1'b1;
        end else begin
            eq = (a == b);
        end
        return eq;
    endfunction

    logic [SAMPLE_WIDTH-1:0] needle_mem [NEEDLE_MAX];
    logic [SAMPLE_WIDTH-1:0] ring_mem   [NEEDLE_MAX];

    back_state_e               state_reg, state_next;
    logic [IDX_W-1:0]          needle_cnt_reg;
    logic [POSITION_WIDTH-1:0] hay_count_reg;
    logic [IDX_W-1:0]          slot_reg;
    logic [POSITION_WIDTH-1:0] first_match_reg;
    logic [1:0]                tally_reg;
    logic [CMP_W-1:0]          lim_reg;
    logic                      room_reg;
    logic [IDX_W-1:0]          k_reg;
    logic [IDX_W-1:0]          pos_reg;
    logic                      hit_reg;
    logic                      rd_valid_reg;
    logic [SAMPLE_WIDTH-1:0]   needle_rd_reg;
    logic [SAMPLE_WIDTH-1:0]   ring_rd_reg;
    logic                      out_valid_reg;
    logic [STATUS_W-1:0]       out_status_reg;
    logic [POSITION_WIDTH-1:0] out_start_reg;

    logic [CNT_W-1:0]          nlen;
    logic [CNT_W-1:0]          nlen_m1;
    logic [IDX_W-1:0]          needle_idx;
    logic [IDX_W-1:0]          needle_cnt_next;
    logic [CMP_W-1:0]          h1, nl, hl, cap, diff, lim_calc;
    logic                      in_window;
    logic                      search_done;
    logic                      out_free;
    logic [IDX_W-1:0]          start_pos;
    logic [CNT_W-1:0]          k_ext;
    logic                      k_last;
    logic [1:0]                tally_upd;
    logic [POSITION_WIDTH-1:0] first_upd;
    logic                      needle_we;
    logic                      ring_we;
    logic                      tally_go;
    logic                      out_load;
    status_e                   status_calc;

    // Effective needle length: zero counts as one, and it saturates at the store depth.
    always_comb begin
        if (needle_length == '0) begin
            nlen = CNT_W'(1);
        end else if (32'(needle_length) > 32'(NEEDLE_MAX)) begin
            nlen = RING_DEPTH;
        end else begin
            nlen = CNT_W'(needle_length);
        end
    end

    assign nlen_m1 = nlen - 1'b1;

    always_comb begin
        needle_idx      = ({1'b0, needle_cnt_reg} >= nlen) ? '0 : needle_cnt_reg;
        needle_cnt_next = ({1'b0, needle_idx} + 1'b1 >= nlen) ? '0 : needle_idx + 1'b1;
    end

    assign h1  = CMP_W'(hay_count_reg) + CMP_W'(1);
    assign nl  = CMP_W'(nlen);
    assign hl  = CMP_W'(haystack_length);
    assign cap = CMP_W'(search_cap);

    assign diff     = hl - nl;
    assign lim_calc = (cap < diff) ? cap : diff;

    assign in_window   = room_reg && (h1 >= nl) && (h1 <= lim_reg);
    assign search_done = (h1 >= hl);
    assign out_free    = !out_valid_reg || m_ready;

    // The oldest sample of the candidate occurrence sits nlen - 1 slots behind the newest.
    always_comb begin
        if ({1'b0, slot_reg} >= nlen_m1) begin
            start_pos = slot_reg - nlen_m1[IDX_W-1:0];
        end else begin
            start_pos = IDX_W'({1'b0, slot_reg} + RING_DEPTH - nlen_m1);
        end
    end

    assign k_ext  = {1'b0, k_reg};
    assign k_last = (k_ext == nlen_m1);

    always_comb begin
        tally_upd = tally_reg;
        first_upd = first_match_reg;
        if (hit_reg) begin
            if (tally_reg != 2'd2) begin
                tally_upd = tally_reg + 1'b1;
            end
            if (tally_reg == 2'd0) begin
                first_upd = POSITION_WIDTH'(h1 - nl);
            end
        end
    end

    always_comb begin
        unique case (tally_upd)
            2'd0:    status_calc = STATUS_NONE;
            2'd1:    status_calc = STATUS_UNIQUE;
            default: status_calc = STATUS_SEVERAL;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (q_ctrl.valid && q_ctrl.kind == ITEM_HAYSTACK) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = in_window ? ST_CMP : ST_TALLY;
            end
            ST_CMP: begin
                if (k_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_TALLY;
            end
            ST_TALLY: begin
                if (!search_done || out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        q_pop     = (state_reg == ST_IDLE) && q_ctrl.valid;
        needle_we = q_pop && (q_ctrl.kind == ITEM_NEEDLE);
        ring_we   = q_pop && (q_ctrl.kind == ITEM_HAYSTACK);
        tally_go  = (state_reg == ST_TALLY) && (!search_done || out_free);
        out_load  = tally_go && search_done;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            needle_cnt_reg  <= '0;
            hay_count_reg   <= '0;
            slot_reg        <= '0;
            first_match_reg <= '0;
            tally_reg       <= '0;
            hit_reg         <= 1'b0;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_valid_reg <= (state_reg == ST_CMP);
            if (needle_we) begin
                needle_cnt_reg <= needle_cnt_next;
            end
            if (state_reg == ST_DECIDE) begin
                hit_reg <= in_window;
            end else if (rd_valid_reg) begin
                hit_reg <= hit_reg && samples_equal(ring_rd_reg, needle_rd_reg);
            end
            if (tally_go) begin
                if (search_done) begin
                    hay_count_reg   <= '0;
                    slot_reg        <= '0;
                    first_match_reg <= '0;
                    tally_reg       <= '0;
                end else begin
                    hay_count_reg   <= POSITION_WIDTH'(h1);
                    slot_reg        <= (slot_reg == LAST_SLOT) ? '0 : slot_reg + 1'b1;
                    first_match_reg <= first_upd;
                    tally_reg       <= tally_upd;
                end
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            room_reg <= (hl >= nl);
            lim_reg  <= lim_calc;
        end
        if (state_reg == ST_DECIDE) begin
            k_reg   <= '0;
            pos_reg <= start_pos;
        end else if (state_reg == ST_CMP) begin
            k_reg   <= k_reg + 1'b1;
            pos_reg <= (pos_reg == LAST_SLOT) ? '0 : pos_reg + 1'b1;
        end
        if (out_load) begin
            out_status_reg <= status_calc;
            out_start_reg  <= (tally_upd == 2'd1) ? first_upd : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (needle_we) begin
            needle_mem[needle_idx] <= q_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring_mem[slot_reg] <= q_sample;
        end
    end

    always_ff @(posedge aclk) begin
        needle_rd_reg <= needle_mem[k_reg];
        ring_rd_reg   <= ring_mem[pos_reg];
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_match_start = out_start_reg;

    `UWPS_ASSERT_IMPL(a_cmp_index, aclk, aresetn, state_reg == ST_CMP, k_ext < nlen, "needle index beyond needle length")
    `UWPS_ASSERT_IMPL(a_drained, aclk, aresetn, state_reg == ST_TALLY, !rd_valid_reg, "tally taken before last compare")
    `UWPS_ASSERT_NEXT(a_clear_after_result, aclk, aresetn, out_load, hay_count_reg == '0 && tally_reg == 2'd0 && slot_reg == '0, "search state not cleared after result")
    `UWPS_ASSERT_IMPL(a_tally_range, aclk, aresetn, 1'b1, tally_reg != 2'd3, "match tally out of range")
    `UWPS_ASSERT_IMPL(a_start_zero, aclk, aresetn, out_valid_reg && out_status_reg != STATUS_UNIQUE, out_start_reg == '0, "start nonzero without unique match")

endmodule

// ===== rtl/unique_window_pattern_search_core.sv =====
// Exact search of a needle of float samples in a stream of haystack samples.
// Input beats on s_*: tuser[0] is the mode (0 loads the next needle sample, 1 is
// a haystack sample), tdata carries the raw sample bits. After the last haystack
// sample of a search (haystack_length samples) one result beat leaves on m_*:
// tuser holds the status (unique, none, several), tdata the start of the unique
// match. Registers must be written by the user on the cfg_* channel only while
// the block is idle; the block itself does not enforce this. A haystack sample
// whose occurrence lies in the search window goes through the compare loop,
// which reads one needle word and one ring word per cycle through single memory
// ports. A two-beat input queue lets the input side keep moving while the
// compare loop runs. After the final compare the tally state counts the match,
// and the result is then registered in the output register.
// Reset returns the registers to their defaults and clears the queue and the
// search state; the needle and ring memories are not cleared, and the needle
// must be loaded before searching. If the receiver stalls, the result waits in
// the output register; the block then holds at the end of the next search
// until the register is free, and the input queue fills and drops s_tready.
module unique_window_pattern_search_core import uwps_pkg::*; #(
    parameter int NEEDLE_MAX     = NEEDLE_MAX_DEFAULT,
    parameter int POSITION_WIDTH = POSITION_WIDTH_DEFAULT,
    parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEFAULT,
    localparam int IN_DATA_W     = ((SAMPLE_WIDTH + 7) / 8) * 8,
    localparam int OUT_DATA_W    = ((POSITION_WIDTH + 7) / 8) * 8,
    localparam int CFG_DATA_W    = (POSITION_WIDTH > NLEN_REG_W) ? POSITION_WIDTH : NLEN_REG_W
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_DATA_W-1:0]   s_tdata,   // sample_bits
    input  logic [0:0]             s_tuser,   // mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // match_start
    output logic [STATUS_W-1:0]    m_tuser,   // status
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [NLEN_REG_W-1:0]     needle_length_reg;
    logic [POSITION_WIDTH-1:0] haystack_length_reg;
    logic [POSITION_WIDTH-1:0] search_cap_reg;

    q_ctrl_t                   q_ctrl;
    logic [SAMPLE_WIDTH-1:0]   q_sample;
    logic                      q_pop;
    logic [POSITION_WIDTH-1:0] match_start;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            needle_length_reg   <= NLEN_REG_W'(RESET_NEEDLE_LENGTH);
            haystack_length_reg <= POSITION_WIDTH'(RESET_HAYSTACK_LENGTH);
            search_cap_reg      <= POSITION_WIDTH'(RESET_SEARCH_CAP);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_NEEDLE_LENGTH:   needle_length_reg   <= cfg_data[NLEN_REG_W-1:0];
                CFG_HAYSTACK_LENGTH: haystack_length_reg <= cfg_data[POSITION_WIDTH-1:0];
                CFG_SEARCH_CAP:      search_cap_reg      <= cfg_data[POSITION_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    uwps_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_mode   (s_tuser[0]),
        .s_sample (s_tdata[SAMPLE_WIDTH-1:0]),
        .q_ctrl   (q_ctrl),
        .q_sample (q_sample),
        .q_pop    (q_pop)
    );

    uwps_back #(
        .NEEDLE_MAX     (NEEDLE_MAX),
        .POSITION_WIDTH (POSITION_WIDTH),
        .SAMPLE_WIDTH   (SAMPLE_WIDTH)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_ctrl          (q_ctrl),
        .q_sample        (q_sample),
        .q_pop           (q_pop),
        .needle_length   (needle_length_reg),
        .haystack_length (haystack_length_reg),
        .search_cap      (search_cap_reg),
        .m_valid         (m_tvalid),
        .m_ready         (m_tready),
        .m_status        (m_tuser),
        .m_match_start   (match_start)
    );

    assign m_tdata = OUT_DATA_W'(match_start);

endmodule
